>>> design/sevt_pkg.sv
// shared types, constants and codes of the sorted enum value table
package sevt_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] KIND_DEFINE = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [31:0] BYTE_LIMIT = 32'd256;
  localparam logic [31:0] HALF_LIMIT = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic        has_explicit;
    logic [31:0] explicit_value;
    logic [31:0] lookup_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [5:0]  position;
    logic [5:0]  ordinal;
    logic [31:0] assigned_value;
    logic [6:0]  entry_count;
    logic [1:0]  size_class;
    logic        zeroable;
  } result_t;

  typedef struct packed {
    logic [31:0]   value;
    logic [AW-1:0] ordinal;
  } entry_t;

  typedef struct packed {
    logic load;
    logic probe_rd;
    logic probe_cmp;
    logic shift_rd;
    logic shift_wr;
    logic insert;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic search_done;
    logic dup;
    logic shift_done;
    logic is_define;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_FINISH
  } state_e;

endpackage

>>> design/sevt_ctrl.sv
// sequencing state machine of the sorted enum value table
module sevt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [1:0]             kind_i,
  input  sevt_pkg::dp_status_t   status_i,
  output sevt_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);
  import sevt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_LOOKUP) begin
            state_d = ST_SEARCH;
          end else if (kind_i == KIND_DEFINE && !status_i.full) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        if (!status_i.search_done) begin
          state_d = ST_PROBE;
        end else if (status_i.is_define && !status_i.dup) begin
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_PROBE:    state_d = ST_SEARCH;
      ST_SHIFT_RD: state_d = status_i.shift_done ? ST_INSERT : ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_INSERT:   state_d = ST_FINISH;
      ST_FINISH:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SEARCH:   cmd_o.probe_rd  = !status_i.search_done;
      ST_PROBE:    cmd_o.probe_cmp = 1'b1;
      ST_SHIFT_RD: cmd_o.shift_rd  = !status_i.shift_done;
      ST_SHIFT_WR: cmd_o.shift_wr  = 1'b1;
      ST_INSERT:   cmd_o.insert    = 1'b1;
      ST_FINISH:   cmd_o.finish    = 1'b1;
      default:     busy_o          = 1'b1;
    endcase
  end

  // the next beat is taken only after the result has been loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy_o)
    else $error("accepted beat did not make the block busy");

endmodule

>>> design/sevt_dp.sv
// datapath of the sorted enum value table: storage, search, shift and result
module sevt_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sevt_pkg::item_t        item_i,
  input  sevt_pkg::ctrl_cmd_t    cmd_i,
  output sevt_pkg::dp_status_t   status_o,
  output sevt_pkg::result_t      result_o,
  output logic                   result_valid_o
);
  import sevt_pkg::*;

  entry_t        mem_q [MAX_ENTRIES];
  entry_t        rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [1:0]    kind_q;
  logic          full_q;
  logic [31:0]   key_q;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          cand_valid_q, cand_eq_q;
  logic [AW-1:0] cand_ord_q;
  logic [CW-1:0] ptr_q;
  logic [CW-1:0] count_q;
  logic [31:0]   next_auto_q;
  logic [31:0]   min_q, max_q;
  result_t       result_q, result_d;
  logic          result_valid_q;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] ptr_dec;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign ptr_dec = ptr_q - CW'(1);

  assign status_o.full        = (count_q >= CW'(MAX_ENTRIES));
  assign status_o.search_done = (lo_q >= hi_q);
  assign status_o.dup         = cand_valid_q && cand_eq_q;
  assign status_o.shift_done  = (ptr_q == lo_q);
  assign status_o.is_define   = (kind_q == KIND_DEFINE);

  // memory port selection
  always_comb begin
    mem_re    = cmd_i.probe_rd || cmd_i.shift_rd;
    mem_raddr = cmd_i.probe_rd ? mid[AW-1:0] : ptr_dec[AW-1:0];
    mem_we    = cmd_i.shift_wr || cmd_i.insert;
    mem_waddr = cmd_i.insert ? lo_q[AW-1:0] : ptr_q[AW-1:0];
    mem_wdata = cmd_i.insert ? entry_t'{value: key_q, ordinal: count_q[AW-1:0]} : rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // search bounds
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = count_q;
    end else if (cmd_i.probe_cmp) begin
      if (rdata_q.value < key_q) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.load) begin
      kind_q <= item_i.kind;
      full_q <= status_o.full;
      ptr_q  <= count_q;
      if (item_i.kind == KIND_LOOKUP) begin
        key_q <= item_i.lookup_value;
      end else begin
        key_q <= item_i.has_explicit ? item_i.explicit_value : next_auto_q;
      end
    end
    if (cmd_i.probe_cmp && !(rdata_q.value < key_q)) begin
      cand_eq_q  <= (rdata_q.value == key_q);
      cand_ord_q <= rdata_q.ordinal;
    end
    if (cmd_i.shift_wr) begin
      ptr_q <= ptr_dec;
    end
    if (cmd_i.insert) begin
      cand_ord_q <= count_q[AW-1:0];
    end
  end

  // table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      next_auto_q  <= '0;
      cand_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cand_valid_q <= 1'b0;
        if (item_i.kind == KIND_CLEAR) begin
          count_q     <= '0;
          next_auto_q <= '0;
        end
      end
      if (cmd_i.probe_cmp && !(rdata_q.value < key_q)) begin
        cand_valid_q <= 1'b1;
      end
      if (cmd_i.insert) begin
        count_q     <= count_q + CW'(1);
        next_auto_q <= key_q + 32'd1;
      end
    end
  end

  // extremes kept alongside the memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      if (lo_q == '0) begin
        min_q <= key_q;
      end
      if (lo_q == count_q) begin
        max_q <= key_q;
      end
    end
  end

  always_comb begin
    result_d = '0;
    result_d.entry_count = 7'(count_q);
    if (count_q != '0) begin
      if (max_q < BYTE_LIMIT) begin
        result_d.size_class = SIZE_BYTE;
      end else if (max_q < HALF_LIMIT) begin
        result_d.size_class = SIZE_HALF;
      end else begin
        result_d.size_class = SIZE_WORD;
      end
      result_d.zeroable = (min_q == 32'd0);
    end
    case (kind_q)
      KIND_DEFINE: begin
        result_d.assigned_value = key_q;
        if (full_q) begin
          result_d.status = STATUS_FULL;
        end else begin
          result_d.status   = status_o.dup ? STATUS_DUP : STATUS_OK;
          result_d.position = 6'(lo_q);
          result_d.ordinal  = 6'(cand_ord_q);
        end
      end
      KIND_LOOKUP: begin
        result_d.position = 6'(lo_q);
        if (status_o.dup) begin
          result_d.found   = 1'b1;
          result_d.ordinal = 6'(cand_ord_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.finish;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (count_q < CW'(MAX_ENTRIES)) && (lo_q <= count_q))
    else $error("insert into a full table or past the end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> ptr_q > lo_q)
    else $error("shift moved an entry below the insertion point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe held for more than one cycle");

endmodule

>>> design/sorted_enum_value_table_core.sv
// top level of the sorted enum value table: controller plus datapath
// lookup: load, then k rounds of search and probe, then finish and the registered result strobe,
//   k = binary-search probes (at most ceil(log2(count+1)), 7 for a full table)
// define then moves each entry above the slot up by a read and a write, and inserts
// clear, kind 3 and full-table define go straight to the finish state; one beat in flight at a time
// reset clears count, next auto value and the strobe at once; no clearing pass
// results are strobed for one cycle only, the receiver cannot stall
module sorted_enum_value_table_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sevt_pkg::item_t   item_i,
  output sevt_pkg::result_t result_o,
  output logic              result_valid_o
);
  import sevt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencing: search probes, entry shifting and the final result load
  sevt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (item_i.kind),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // sorted memory with the search bounds, counters and result register
  sevt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

>>> bench/testbench.sv
// self-checking testbench for the sorted enum value table core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sevt_pkg::*;

  // kind 3 has no meaning, the block must leave the table alone
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // no beat accepted and no result for this long means the block hung
  // (longer than the slowest define and the longest sender gap)
  localparam int unsigned IDLE_LIMIT = 2000;
  // quiet cycles after the last result, catches stray strobes
  localparam int unsigned TAIL_CYCLES = 200;
  // stop starting random sessions once this many beats went in
  localparam int unsigned ITEM_TARGET = 1200;
  // only the first few mismatches are printed, all are counted
  localparam int unsigned PRINT_CAP = 40;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t result_o;
  logic    result_valid_o;

  sorted_enum_value_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the table, kept in value order
  logic [31:0] shadow_val [MAX_ENTRIES];
  logic [5:0]  shadow_ord [MAX_ENTRIES];
  int unsigned shadow_count = 0;
  logic [31:0] shadow_auto  = '0;

  // results owed by the block, oldest first
  result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned dup_seen       = 0;
  int unsigned full_seen      = 0;
  int unsigned hit_seen       = 0;
  int unsigned miss_seen      = 0;

  // sender pacing
  bit          pacing_on  = 1'b0;
  int unsigned burst_left = 0;

  // first slot whose value is not below v, 0..shadow_count
  function automatic int unsigned slot_of(logic [31:0] v);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_val[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // applies one accepted beat to the shadow table and returns the result it owes
  function automatic result_t predict_beat(item_t it);
    result_t     r;
    int unsigned p, i;
    logic [31:0] v, top;
    r = '0;
    case (it.kind)
      KIND_DEFINE: begin
        v = it.has_explicit ? it.explicit_value : shadow_auto;
        r.assigned_value = v;
        // a full table wins over a duplicate
        if (shadow_count >= MAX_ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          p = slot_of(v);
          if (p < shadow_count && shadow_val[p] == v) begin
            // clash names the entry already there
            r.status   = STATUS_DUP;
            r.position = p[5:0];
            r.ordinal  = shadow_ord[p];
          end else begin
            // open a hole at p by moving the upper entries up one slot
            for (i = shadow_count; i > p; i--) begin
              shadow_val[i] = shadow_val[i-1];
              shadow_ord[i] = shadow_ord[i-1];
            end
            shadow_val[p] = v;
            shadow_ord[p] = shadow_count[5:0];
            r.status      = STATUS_OK;
            r.position    = p[5:0];
            r.ordinal     = shadow_count[5:0];
            shadow_count++;
            // wraps at 32 bits
            shadow_auto = v + 32'd1;
          end
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        shadow_auto  = '0;
      end
      KIND_LOOKUP: begin
        // on a miss the position is where the value would go
        p = slot_of(it.lookup_value);
        r.position = p[5:0];
        if (p < shadow_count && shadow_val[p] == it.lookup_value) begin
          r.found   = 1'b1;
          r.ordinal = shadow_ord[p];
          hit_seen++;
        end else begin
          miss_seen++;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_count[6:0];
    // empty table reports byte class and not zeroable
    if (shadow_count > 0) begin
      top = shadow_val[shadow_count-1];
      r.size_class = (top < BYTE_LIMIT) ? SIZE_BYTE :
                     (top < HALF_LIMIT) ? SIZE_HALF : SIZE_WORD;
      r.zeroable   = (shadow_val[0] == 32'd0);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
               what, results_seen, got, want);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result strobe with nothing pending", got.assigned_value, 32'd0);
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.found !== want.found)
      report_mismatch("found", 32'(got.found), 32'(want.found));
    if (got.position !== want.position)
      report_mismatch("position", 32'(got.position), 32'(want.position));
    if (got.ordinal !== want.ordinal)
      report_mismatch("ordinal", 32'(got.ordinal), 32'(want.ordinal));
    if (got.assigned_value !== want.assigned_value)
      report_mismatch("assigned_value", got.assigned_value, want.assigned_value);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    if (got.size_class !== want.size_class)
      report_mismatch("size_class", 32'(got.size_class), 32'(want.size_class));
    if (got.zeroable !== want.zeroable)
      report_mismatch("zeroable", 32'(got.zeroable), 32'(want.zeroable));
    if (want.status == STATUS_DUP) dup_seen++;
    if (want.status == STATUS_FULL) full_seen++;
  endtask

  // monitor: check the result first, it always belongs to an older beat,
  // then predict the beat taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) check_result(result_o);
      if (start && !busy) begin
        pending_results.push_back(predict_beat(item_i));
        beats_sent++;
      end
    end
  end

  // watchdog on cycles with no progress at all
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no beat and no result for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------
  // driving, always entered and left at a falling edge
  // ---------------------------------------------------------------

  // present one beat and hold it until the block takes it
  task automatic send_beat(item_t it);
    item_i <= it;
    start  <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // start low for the number of cycles asked for
  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // bursts of back-to-back beats split by random gaps; the long gaps reach
  // past a whole table shift so they land on every phase of the work
  task automatic pace_and_send(item_t it);
    if (pacing_on) begin
      if (burst_left == 0) begin
        pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(20, 160)
                                                 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    send_beat(it);
  endtask

  // hold off until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------
  // beat builders, unused fields carry random junk
  // ---------------------------------------------------------------

  function automatic item_t define_item(bit explicit_on, logic [31:0] v);
    item_t it;
    it                = '0;
    it.kind           = KIND_DEFINE;
    it.has_explicit   = explicit_on;
    it.explicit_value = explicit_on ? v : $urandom;
    it.lookup_value   = $urandom;
    return it;
  endfunction

  function automatic item_t lookup_item(logic [31:0] v);
    item_t it;
    it                = '0;
    it.kind           = KIND_LOOKUP;
    it.has_explicit   = ($urandom_range(0, 1) == 1);
    it.explicit_value = $urandom;
    it.lookup_value   = v;
    return it;
  endfunction

  function automatic item_t other_item(logic [1:0] k);
    item_t it;
    it                = '0;
    it.kind           = k;
    it.has_explicit   = ($urandom_range(0, 1) == 1);
    it.explicit_value = $urandom;
    it.lookup_value   = $urandom;
    return it;
  endfunction

  // values spread over the size class boundaries and both ends of the range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 255);
      1: return $urandom_range(256, 65535);
      2: return $urandom;
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: return $urandom_range(0, 3);
      5: return $urandom_range(250, 262);
      default: return $urandom_range(65530, 65541);
    endcase
  endfunction

  // a value currently in the table, caller makes sure it is not empty
  function automatic logic [31:0] held_value();
    return shadow_val[$urandom_range(0, shadow_count - 1)];
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // lookups, clear and the spare kind on an empty table
  task automatic test_empty_table();
    pace_and_send(lookup_item(32'd0));
    pace_and_send(lookup_item(32'hFFFF_FFFF));
    pace_and_send(other_item(KIND_SPARE));
    pace_and_send(other_item(KIND_CLEAR));
  endtask

  // automatic numbering, duplicates, the wrap past the top value
  task automatic test_auto_numbering();
    pace_and_send(define_item(1'b0, '0));            // gets 0, zeroable
    pace_and_send(define_item(1'b0, '0));            // gets 1
    pace_and_send(define_item(1'b1, 32'd5));
    pace_and_send(define_item(1'b0, '0));            // gets 6
    pace_and_send(define_item(1'b1, 32'd3));         // lands in the middle
    pace_and_send(define_item(1'b1, 32'd5));         // duplicate
    pace_and_send(lookup_item(32'd3));
    pace_and_send(lookup_item(32'd4));               // miss between entries
    pace_and_send(define_item(1'b1, 32'hFFFF_FFFF));
    pace_and_send(define_item(1'b0, '0));            // wraps to 0, duplicate
    pace_and_send(lookup_item(32'hFFFF_FFFF));
    pace_and_send(other_item(KIND_SPARE));           // nonempty, no change
    pace_and_send(other_item(KIND_CLEAR));
    pace_and_send(define_item(1'b0, '0));            // numbering restarts at 0
  endtask

  // the edges of the byte and halfword size classes
  task automatic test_size_classes();
    pace_and_send(other_item(KIND_CLEAR));
    pace_and_send(define_item(1'b1, 32'd255));
    pace_and_send(define_item(1'b1, 32'd256));
    pace_and_send(define_item(1'b1, 32'd65535));
    pace_and_send(define_item(1'b1, 32'd65536));
    pace_and_send(lookup_item(32'd65536));
  endtask

  // fill all entries, then defines must be refused as full
  task automatic test_fill_to_full(bit descending);
    int unsigned k;
    logic [31:0] base, step;
    pace_and_send(other_item(KIND_CLEAR));
    if (descending) begin
      // every insert goes to slot 0 and moves the whole table
      base = 32'hF000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
      step = $urandom_range(1, 32'h00FF_FFFF);
      for (k = 0; k < MAX_ENTRIES; k++)
        pace_and_send(define_item(1'b1, base - k * step));
    end else begin
      // start near the top and let automatic values wrap through zero
      pace_and_send(define_item(1'b1, 32'hFFFF_FFFF - $urandom_range(0, 63)));
      for (k = 1; k < MAX_ENTRIES; k++)
        pace_and_send(define_item(1'b0, '0));
    end
    // full is checked before duplicates
    pace_and_send(define_item(1'b1, held_value()));
    pace_and_send(define_item(1'b0, '0));
    pace_and_send(define_item(1'b1, pick_value()));
    pace_and_send(lookup_item(shadow_val[0]));
    pace_and_send(lookup_item(shadow_val[MAX_ENTRIES - 1]));
    for (k = 0; k < 8; k++) pace_and_send(lookup_item(held_value()));
    for (k = 0; k < 4; k++) pace_and_send(lookup_item(pick_value()));
    pace_and_send(other_item(KIND_SPARE));
  endtask

  // sessions of defines and lookups, mostly on a freshly cleared table, with some noise
  task automatic test_random_sessions();
    int unsigned target, ops, n, roll;
    while (beats_sent < ITEM_TARGET) begin
      pacing_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) != 0) pace_and_send(other_item(KIND_CLEAR));
      // mostly short tables, now and then one that runs full
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
      ops = $urandom_range(target, 3 * target);
      for (n = 0; n < ops; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          if ($urandom_range(0, 9) < 3) pace_and_send(define_item(1'b0, '0));
          else pace_and_send(define_item(1'b1, pick_value()));
        end else if (roll < 50) begin
          if (shadow_count > 0) pace_and_send(define_item(1'b1, held_value()));
          else pace_and_send(define_item(1'b0, '0));
        end else if (roll < 90) begin
          case ($urandom_range(0, 4))
            0, 1, 2: pace_and_send(lookup_item(shadow_count > 0 ? held_value() : pick_value()));
            3: pace_and_send(lookup_item(shadow_count > 0 ? held_value() + 32'd1 : pick_value()));
            default: pace_and_send(lookup_item(pick_value()));
          endcase
        end else if (roll < 95) begin
          pace_and_send(other_item(KIND_SPARE));
        end else if (roll < 97) begin
          pace_and_send(other_item(KIND_CLEAR));
        end else begin
          pace_and_send(lookup_item(shadow_count > 0 ? held_value() - 32'd1 : pick_value()));
        end
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part back to back, no gaps
    pacing_on = 1'b0;
    test_empty_table();
    test_auto_numbering();
    test_size_classes();
    // sender holds off until the block has answered everything
    wait_drained();

    pacing_on = 1'b1;
    test_fill_to_full(1'b1);
    test_fill_to_full(1'b0);
    test_random_sessions();

    wait_drained();
    start <= 1'b0;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", pending_results.size(), 32'd0);

    $display("sent %0d beats, checked %0d results: %0d lookup hits, %0d misses",
             beats_sent, results_seen, hit_seen, miss_seen);
    $display("duplicate rejects %0d, full-table rejects %0d, mismatches %0d",
             dup_seen, full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sevt_pkg.sv
design/sevt_ctrl.sv
design/sevt_dp.sv
design/sorted_enum_value_table_core.sv
bench/testbench.sv
